@@ hdl/tri_stiff_pkg.sv @@
package tri_stiff_pkg;

  // corner coordinate and derived widths
  localparam int CRDW = 32;               // input coordinate
  localparam int CW   = CRDW + 1;         // b_i / c_i differences
  localparam int DW   = 68;               // signed twice-area
  localparam int DMW  = DW - 1;           // its magnitude
  localparam int QW   = 33;               // 2^32 - p^2
  localparam int MW   = 102;              // divisor 4*|det|*(2^32 - p^2)
  localparam int GLW  = 23;               // limb of |det| for the divisor product
  localparam int PRW  = 2 * CW;           // b/c products
  localparam int TW   = PRW + 20;         // weighted products and their sum
  localparam int GMW  = 83;               // |G| magnitude
  localparam int LIMBW = 28;              // limb of |G| for the modulus product
  localparam int EW   = 32;               // modulus
  localparam int NUW  = 15;               // Poisson ratio
  localparam int PW   = GMW + EW;         // |G| * E
  localparam int QTW  = 64;               // quotient / entry width
  localparam int LANES = 6;
  localparam int ROWW  = 3;
  localparam int IN_DW  = 6 * CRDW;
  localparam int OUT_DW = ((ROWW + LANES * QTW + 7) / 8) * 8;

  localparam logic [ROWW-1:0] LAST_ROW = 3'd5;

  localparam logic [0:0] REG_YOUNG   = 1'b0;
  localparam logic [0:0] REG_POISSON = 1'b1;

  localparam logic [EW-1:0]  YOUNG_RESET   = 32'd1;
  localparam logic [NUW-1:0] POISSON_RESET = 15'd19661;

  localparam logic [QTW-1:0] ENTRY_MAX = {1'b0, {(QTW-1){1'b1}}};
  localparam logic [QTW-1:0] ENTRY_MIN = {1'b1, {(QTW-1){1'b0}}};

  typedef logic signed [CW-1:0] diff_t;

  typedef struct packed {
    diff_t [2:0]     b;
    diff_t [2:0]     c;
    logic [MW-1:0]   m;
    logic            degen;
  } geom_t;

  typedef struct packed {
    logic            valid;
    logic [ROWW-1:0] row;
    logic            degen;
    logic            last;
  } row_ctx_t;

endpackage

@@ hdl/tri_stiff_geom.sv @@
module tri_stiff_geom (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [2:0][tri_stiff_pkg::CRDW-1:0]     xs,
  input  logic [2:0][tri_stiff_pkg::CRDW-1:0]     ys,
  input  logic [tri_stiff_pkg::NUW-1:0]           poisson,
  output logic                                    out_valid,
  output tri_stiff_pkg::geom_t                    geom
);
  import tri_stiff_pkg::*;

  logic [5:0] vld;

  diff_t [2:0] b1, c1, b2, c2, b3, c3, b4, c4, b5, c5, b6, c6;
  logic signed [CRDW-1:0] x1 [3];
  logic [QW-1:0] q1, q2, q3, q4;
  logic signed [PRW-2:0] pr2 [3];
  logic signed [DW-1:0] det3;
  logic [DMW-1:0] mag4;
  logic degen4, degen5, degen6;
  logic [GLW+QW-1:0] pp5 [3];
  logic [MW-1:0] m6;
  logic [3*GLW-1:0] mag_pad;

  assign mag_pad = (3*GLW)'(mag4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors of each corner
      for (int i = 0; i < 3; i++) begin
        b1[i] <= $signed({ys[(i+1)%3][CRDW-1], ys[(i+1)%3]})
               - $signed({ys[(i+2)%3][CRDW-1], ys[(i+2)%3]});
        c1[i] <= $signed({xs[(i+2)%3][CRDW-1], xs[(i+2)%3]})
               - $signed({xs[(i+1)%3][CRDW-1], xs[(i+1)%3]});
        x1[i] <= $signed(xs[i]);
      end
      q1 <= (QW'(1) << 32) - (QW'(poisson) * QW'(poisson));

      for (int i = 0; i < 3; i++) begin
        pr2[i] <= x1[i] * $signed(b1[i]);
      end
      b2 <= b1; c2 <= c1; q2 <= q1;

      det3 <= DW'(pr2[0]) + DW'(pr2[1]) + DW'(pr2[2]);
      b3 <= b2; c3 <= c2; q3 <= q2;

      mag4   <= DMW'(det3[DW-1] ? -det3 : det3);
      degen4 <= (det3 == '0);
      b4 <= b3; c4 <= c3; q4 <= q3;

      for (int k = 0; k < 3; k++) begin
        pp5[k] <= (GLW+QW)'(mag_pad[k*GLW +: GLW]) * (GLW+QW)'(q4);
      end
      degen5 <= degen4;
      b5 <= b4; c5 <= c4;

      m6 <= (MW'(pp5[0]) + (MW'(pp5[1]) << GLW) + (MW'(pp5[2]) << (2*GLW))) << 2;
      degen6 <= degen5;
      b6 <= b5; c6 <= c5;
    end
  end

  assign out_valid  = vld[5];
  assign geom.b     = b6;
  assign geom.c     = c6;
  assign geom.m     = m6;
  assign geom.degen = degen6;

endmodule

@@ hdl/tri_stiff_entry.sv @@
module tri_stiff_entry (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tri_stiff_pkg::CW-1:0] f1,
  input  logic signed [tri_stiff_pkg::CW-1:0] f2,
  input  logic signed [tri_stiff_pkg::CW-1:0] g1,
  input  logic signed [tri_stiff_pkg::CW-1:0] g2,
  input  logic [17:0]                       alpha,
  input  logic [16:0]                       beta,
  input  logic [tri_stiff_pkg::EW-1:0]      modulus,
  output logic [tri_stiff_pkg::PW-1:0]      prod,
  output logic                              neg
);
  import tri_stiff_pkg::*;

  logic signed [PRW-1:0] p1, p2;
  logic [17:0] al1;
  logic [16:0] be1;
  logic signed [TW-1:0] t1, t2, g3;
  logic [GMW-1:0] mag4;
  logic neg4, neg5;
  logic [LIMBW+EW-1:0] pp5 [3];
  logic [3*LIMBW-1:0] mag_pad;

  assign mag_pad = (3*LIMBW)'(mag4);

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= f1 * f2;
      p2  <= g1 * g2;
      al1 <= alpha;
      be1 <= beta;

      t1 <= $signed({1'b0, al1}) * p1;
      t2 <= $signed({1'b0, be1}) * p2;

      g3 <= t1 + t2;

      neg4 <= g3[TW-1];
      mag4 <= GMW'(g3[TW-1] ? -g3 : g3);

      for (int k = 0; k < 3; k++) begin
        pp5[k] <= (LIMBW+EW)'(mag_pad[k*LIMBW +: LIMBW]) * (LIMBW+EW)'(modulus);
      end
      neg5 <= neg4;

      prod <= PW'(pp5[0]) + (PW'(pp5[1]) << LIMBW) + (PW'(pp5[2]) << (2*LIMBW));
      neg  <= neg5;
    end
  end

endmodule

@@ hdl/tri_stiff_div.sv @@
module tri_stiff_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic [tri_stiff_pkg::LANES-1:0][tri_stiff_pkg::PW-1:0] prod_in,
  input  logic [tri_stiff_pkg::LANES-1:0]                        neg_in,
  input  logic [tri_stiff_pkg::MW-1:0]                           m_in,
  input  tri_stiff_pkg::row_ctx_t                                ctx_in,
  output logic [tri_stiff_pkg::LANES-1:0][tri_stiff_pkg::QTW-1:0] quot,
  output logic [tri_stiff_pkg::LANES-1:0]                        big,
  output logic [tri_stiff_pkg::LANES-1:0]                        neg_out,
  output tri_stiff_pkg::row_ctx_t                                ctx_out
);
  import tri_stiff_pkg::*;

  localparam int K    = 16 + FRAC_BITS;
  localparam int NW   = PW + K + 1;
  localparam int HW   = NW - QTW;
  localparam int CMPW = (HW > MW) ? HW : MW;

  // numerator = |G|*E*2^K + M/2
  logic [NW-1:0] na [LANES];
  logic [MW-1:0] ma;
  logic [LANES-1:0] nega;
  row_ctx_t ctxa;

  logic [MW-1:0]    r_st   [QTW+1][LANES];
  logic [QTW-1:0]   q_st   [QTW+1][LANES];
  logic [MW-1:0]    m_st   [QTW+1];
  logic [LANES-1:0] neg_st [QTW+1];
  logic [LANES-1:0] big_st [QTW+1];
  row_ctx_t         ctx_st [QTW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctxa      <= '0;
      ctx_st[0] <= '0;
    end else if (en) begin
      ctxa      <= ctx_in;
      ctx_st[0] <= ctxa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        na[l] <= NW'({prod_in[l], {K{1'b0}}}) + NW'(m_in >> 1);
      end
      ma   <= m_in;
      nega <= neg_in;

      // quotient of 2^64 or more only saturates
      for (int l = 0; l < LANES; l++) begin
        big_st[0][l] <= CMPW'(na[l][NW-1:QTW]) >= CMPW'(ma);
        r_st[0][l]   <= MW'(na[l][NW-1:QTW]);
        q_st[0][l]   <= na[l][QTW-1:0];
      end
      m_st[0]   <= ma;
      neg_st[0] <= nega;
    end
  end

  // one restoring step per stage, numerator bits shift out as quotient bits shift in
  for (genvar k = 0; k < QTW; k++) begin : g_step
    logic [MW:0]    trial [LANES];
    logic [LANES-1:0] ge;
    logic [MW-1:0]  r_next [LANES];
    logic [QTW-1:0] q_next [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]  = {r_st[k][l], q_st[k][l][QTW-1]};
        ge[l]     = trial[l] >= {1'b0, m_st[k]};
        r_next[l] = ge[l] ? MW'(trial[l] - {1'b0, m_st[k]}) : MW'(trial[l]);
        q_next[l] = {q_st[k][l][QTW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctx_st[k+1] <= '0;
      end else if (en) begin
        ctx_st[k+1] <= ctx_st[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          r_st[k+1][l] <= r_next[l];
          q_st[k+1][l] <= q_next[l];
        end
        m_st[k+1]   <= m_st[k];
        neg_st[k+1] <= neg_st[k];
        big_st[k+1] <= big_st[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot[l] = q_st[QTW][l];
  end
  assign big     = big_st[QTW];
  assign neg_out = neg_st[QTW];
  assign ctx_out = ctx_st[QTW];

endmodule

@@ hdl/triangle_element_stiffness_unit.sv @@
// Constant-strain triangle stiffness, plane stress. Each input transfer carries
// the three corners of one triangle (signed, FRAC_BITS fraction bits); the unit
// answers with six output transfers, rows 0 to 5 of the 6x6 element stiffness
// A*Bt*D*B, each with six signed 64-bit entries (FRAC_BITS fraction bits),
// rounded to nearest with ties away from zero and saturated at the 64-bit
// limits. A zero-area triangle gives all-zero rows with the degenerate flag
// (tuser) set; tlast marks row 5. Modulus and Poisson ratio come from the
// write port and must only change while the unit is empty. Throughput is set
// by the single output channel carrying one row per transfer, six per
// triangle; the row sequencer takes the next triangle while the last row
// of the previous one is still in flight. The path from input transfer to
// the first row runs through 6 geometry stages, the sequencer's hold
// register, 6 entry stages, a 66-stage divider (one quotient bit per stage,
// six lanes side by side) and the output register. Backpressure on the
// output freezes the whole row pipeline; nothing is dropped or repeated.
module triangle_element_stiffness_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // x_first, y_first, x_second, y_second, x_third, y_third (32 bits each)
  input  logic [tri_stiff_pkg::IN_DW-1:0]     s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // row_index[2:0], entry_zero .. entry_five (64 bits each), zero pad
  output logic [tri_stiff_pkg::OUT_DW-1:0]    m_tdata,
  // degenerate
  output logic                                m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_write,
  input  logic [0:0]                          cfg_index,
  input  logic [tri_stiff_pkg::EW-1:0]        cfg_data
);
  import tri_stiff_pkg::*;

  localparam int PAD = OUT_DW - ROWW - LANES * QTW;

  // configuration registers
  logic [EW-1:0]  young;
  logic [NUW-1:0] poisson;

  always_ff @(posedge clk) begin
    if (rst) begin
      young   <= YOUNG_RESET;
      poisson <= POISSON_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_YOUNG:   young   <= cfg_data;
        REG_POISSON: poisson <= cfg_data[NUW-1:0];
        default: ;
      endcase
    end
  end

  // geometry front end: b, c, divisor per triangle
  logic [2:0][CRDW-1:0] xs, ys;
  logic  geom_valid;
  geom_t geom;
  logic  t_adv;

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign xs[i] = s_tdata[(2*i)*CRDW +: CRDW];
    assign ys[i] = s_tdata[(2*i+1)*CRDW +: CRDW];
  end

  tri_stiff_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (t_adv),
    .in_valid  (s_tvalid),
    .xs        (xs),
    .ys        (ys),
    .poisson   (poisson),
    .out_valid (geom_valid),
    .geom      (geom)
  );

  // row sequencer: holds one triangle and issues its six rows
  logic            out_valid;
  logic            r_adv, row_go, row_done, load;
  logic            busy;
  logic [ROWW-1:0] cnt;
  geom_t           hold;

  assign r_adv    = !out_valid || m_tready;
  assign row_go   = busy && r_adv;
  assign row_done = row_go && (cnt == LAST_ROW);
  assign load     = geom_valid && (!busy || row_done);
  assign t_adv    = !geom_valid || load;
  assign s_tready = t_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (row_done) begin
      busy <= 1'b0;
    end else if (row_go) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= geom;
    end
  end

  // entry lanes: G = alpha*P1 + beta*P2, then |G|*E
  // row r = 2a+u, column j = 2b+v: P1 = (u?c_a:b_a)(v?c_b:b_b), P2 = (u?b_a:c_a)(v?b_b:c_b)
  logic [16:0] beta;
  logic [LANES-1:0][PW-1:0] prod;
  logic [LANES-1:0] neg;

  assign beta = 17'h10000 - 17'(poisson);

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    localparam int  BB = j / 2;
    localparam bit  V  = (j % 2) == 1;
    logic signed [CW-1:0] f1, f2, g1, g2;
    logic [17:0] alpha;

    assign f1    = cnt[0] ? hold.c[cnt[2:1]] : hold.b[cnt[2:1]];
    assign g1    = cnt[0] ? hold.b[cnt[2:1]] : hold.c[cnt[2:1]];
    assign f2    = V ? hold.c[BB] : hold.b[BB];
    assign g2    = V ? hold.b[BB] : hold.c[BB];
    assign alpha = (cnt[0] == V) ? 18'h20000 : {2'b00, poisson, 1'b0};

    tri_stiff_entry u_entry (
      .clk     (clk),
      .en      (r_adv),
      .f1      (f1),
      .f2      (f2),
      .g1      (g1),
      .g2      (g2),
      .alpha   (alpha),
      .beta    (beta),
      .modulus (young),
      .prod    (prod[j]),
      .neg     (neg[j])
    );
  end

  // row context and divisor ride alongside the entry lanes
  row_ctx_t      ctx_p [6];
  logic [MW-1:0] m_p   [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 6; s++) begin
        ctx_p[s] <= '0;
      end
    end else if (r_adv) begin
      ctx_p[0].valid <= row_go;
      ctx_p[0].row   <= cnt;
      ctx_p[0].degen <= hold.degen;
      ctx_p[0].last  <= (cnt == LAST_ROW);
      for (int s = 1; s < 6; s++) begin
        ctx_p[s] <= ctx_p[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      m_p[0] <= hold.m;
      for (int s = 1; s < 6; s++) begin
        m_p[s] <= m_p[s-1];
      end
    end
  end

  // rounded quotient per lane
  logic [LANES-1:0][QTW-1:0] quot;
  logic [LANES-1:0] big, dneg;
  row_ctx_t dctx;

  tri_stiff_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (r_adv),
    .prod_in (prod),
    .neg_in  (neg),
    .m_in    (m_p[5]),
    .ctx_in  (ctx_p[5]),
    .quot    (quot),
    .big     (big),
    .neg_out (dneg),
    .ctx_out (dctx)
  );

  // sign, saturate, zero on degenerate; output register
  logic [LANES-1:0][QTW-1:0] ent_next, out_ent;
  logic [ROWW-1:0] out_row;
  logic out_degen, out_last;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dctx.degen) begin
        ent_next[l] = '0;
      end else if (!dneg[l]) begin
        ent_next[l] = (big[l] || quot[l][QTW-1]) ? ENTRY_MAX : quot[l];
      end else if (big[l] || (quot[l][QTW-1] && (quot[l][QTW-2:0] != '0))) begin
        ent_next[l] = ENTRY_MIN;
      end else begin
        ent_next[l] = -quot[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_adv) begin
      out_valid <= dctx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      out_ent   <= ent_next;
      out_row   <= dctx.row;
      out_degen <= dctx.degen;
      out_last  <= dctx.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD{1'b0}}, out_ent, out_row};
  assign m_tuser  = out_degen;
  assign m_tlast  = out_last;

endmodule
